[src/atrpc_pkg.sv]
`timescale 1ns / 1ps

package atrpc_pkg;

  localparam int unsigned MaxAtrBytes = 33;
  localparam int unsigned IdxW = $clog2(MaxAtrBytes + 1);

  typedef logic [IdxW-1:0] idx_t;

  localparam idx_t IdxLimit = idx_t'(MaxAtrBytes);
  localparam idx_t IdxT0 = idx_t'(1);
  localparam idx_t IdxFirstIf = idx_t'(2);

  localparam logic [7:0] MaskDefault = 8'h01;

  typedef struct packed {
    logic [7:0] protocol_mask;
    logic       tck_checked;
    logic       tck_ok;
  } atrpc_result_t;

endpackage

[src/atrpc_if.sv]
`timescale 1ns / 1ps

interface atrpc_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] atr_byte;
  logic       last_byte;

  modport source (output valid, output atr_byte, output last_byte, input ready);
  modport sink (input valid, input atr_byte, input last_byte, output ready);
endinterface

interface atrpc_result_if;
  logic       valid;
  logic       ready;
  logic [7:0] protocol_mask;
  logic       tck_checked;
  logic       tck_ok;

  modport source (output valid, output protocol_mask, output tck_checked, output tck_ok,
                  input ready);
  modport sink (input valid, input protocol_mask, input tck_checked, input tck_ok,
                output ready);
endinterface

[src/atrpc_parser.sv]
`timescale 1ns / 1ps

module atrpc_parser (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    accept_i,
  input  logic [7:0]              atr_byte_i,
  input  logic                    last_byte_i,
  output logic                    res_valid_o,
  output atrpc_pkg::atrpc_result_t res_o
);
  import atrpc_pkg::*;

  idx_t       idx_q, idx_d;
  logic [1:0] skip_q, skip_d;
  logic       td_pend_q, td_pend_d;
  logic       done_q, done_d;
  logic       first_td_q, first_td_d;
  logic       tck_exp_q, tck_exp_d;
  logic [7:0] mask_q, mask_d;
  logic [7:0] xor_q, xor_d;

  logic [3:0] y_nib;
  logic       load_y;
  logic [7:0] proto_bit;

  always_comb begin
    idx_d      = idx_q;
    skip_d     = skip_q;
    td_pend_d  = td_pend_q;
    done_d     = done_q;
    first_td_d = first_td_q;
    tck_exp_d  = tck_exp_q;
    mask_d     = mask_q;
    xor_d      = xor_q;
    y_nib      = atr_byte_i[7:4];
    load_y     = 1'b0;
    proto_bit  = 8'h00;
    proto_bit[atr_byte_i[2:0]] = ~atr_byte_i[3];

    if (idx_q < IdxLimit) begin
      if (idx_q >= IdxT0) begin
        xor_d = xor_q ^ atr_byte_i;
      end
      if (idx_q == IdxT0) begin
        load_y = 1'b1;
      end else if (idx_q >= IdxFirstIf && !done_q) begin
        if (skip_q != 2'd0) begin
          skip_d = skip_q - 2'd1;
        end else if (td_pend_q) begin
          mask_d = mask_q | proto_bit;
          if (!first_td_q) begin
            first_td_d = 1'b1;
            tck_exp_d  = atr_byte_i[0];
          end
          load_y = 1'b1;
        end
      end
      idx_d = idx_q + idx_t'(1);
    end

    if (load_y) begin
      skip_d    = {1'b0, y_nib[0]} + {1'b0, y_nib[1]} + {1'b0, y_nib[2]};
      td_pend_d = y_nib[3];
      done_d    = ~y_nib[3];
    end
  end

  always_comb begin
    res_valid_o         = accept_i && last_byte_i;
    res_o.protocol_mask = 8'h00;
    if (idx_d >= IdxFirstIf) begin
      res_o.protocol_mask = (mask_d != 8'h00) ? mask_d : MaskDefault;
    end
    res_o.tck_checked = first_td_d & tck_exp_d;
    res_o.tck_ok      = first_td_d & tck_exp_d & (xor_d == 8'h00);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q      <= '0;
      skip_q     <= '0;
      td_pend_q  <= 1'b0;
      done_q     <= 1'b0;
      first_td_q <= 1'b0;
      tck_exp_q  <= 1'b0;
      mask_q     <= '0;
      xor_q      <= '0;
    end else if (accept_i) begin
      if (last_byte_i) begin
        idx_q      <= '0;
        skip_q     <= '0;
        td_pend_q  <= 1'b0;
        done_q     <= 1'b0;
        first_td_q <= 1'b0;
        tck_exp_q  <= 1'b0;
        mask_q     <= '0;
        xor_q      <= '0;
      end else begin
        idx_q      <= idx_d;
        skip_q     <= skip_d;
        td_pend_q  <= td_pend_d;
        done_q     <= done_d;
        first_td_q <= first_td_d;
        tck_exp_q  <= tck_exp_d;
        mask_q     <= mask_d;
        xor_q      <= xor_d;
      end
    end
  end

endmodule

[src/atrpc_out_reg.sv]
`timescale 1ns / 1ps

module atrpc_out_reg (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    load_i,
  input  atrpc_pkg::atrpc_result_t res_i,
  input  logic                    out_ready_i,
  output logic                    out_valid_o,
  output atrpc_pkg::atrpc_result_t res_o,
  output logic                    in_ready_o
);
  import atrpc_pkg::*;

  logic          valid_q, valid_d;
  atrpc_result_t res_q;

  assign in_ready_o  = !valid_q || out_ready_i;
  assign out_valid_o = valid_q;
  assign res_o       = res_q;

  always_comb begin
    valid_d = valid_q && !out_ready_i;
    if (load_i) begin
      valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      res_q <= res_i;
    end
  end

endmodule

[src/atr_protocol_and_tck_check.sv]
`timescale 1ns / 1ps

// Answer-to-reset parser. Bytes of one answer-to-reset enter on atr_i, TS
// first, with last_byte set on the final item. Interface bytes announced by
// each Y nibble are skipped, protocol numbers below 8 from every TD byte are
// collected, and bytes from T0 onward are XORed for the TCK check.
// One result item leaves on res_o for each input item marked last; other
// items cause no result. The result appears in the cycle after the marked item
// is accepted. An input item can be accepted every cycle unless stalled; the
// only storage on the path is the parser state and a single output register.
// When the receiver stalls with a result pending, atr_i.ready drops until
// that result is taken; with the output register empty or being drained,
// input keeps flowing. Reset clears the parser state and empties the output
// register, so the next byte is treated as TS. Bytes past the maximum
// answer-to-reset length are ignored, but a last mark on them still ends it.
module atr_protocol_and_tck_check (
  input  logic   clk_i,
  input  logic   rst_ni,
  atrpc_byte_if.sink     atr_i,
  atrpc_result_if.source res_o
);
  import atrpc_pkg::*;

  logic          accept;
  logic          res_valid;
  atrpc_result_t res_next;
  atrpc_result_t res_held;
  logic          in_ready;

  assign atr_i.ready = in_ready;
  assign accept      = atr_i.valid && in_ready;

  atrpc_parser u_parser (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .accept_i    (accept),
    .atr_byte_i  (atr_i.atr_byte),
    .last_byte_i (atr_i.last_byte),
    .res_valid_o (res_valid),
    .res_o       (res_next)
  );

  atrpc_out_reg u_out_reg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (res_valid),
    .res_i       (res_next),
    .out_ready_i (res_o.ready),
    .out_valid_o (res_o.valid),
    .res_o       (res_held),
    .in_ready_o  (in_ready)
  );

  assign res_o.protocol_mask = res_held.protocol_mask;
  assign res_o.tck_checked   = res_held.tck_checked;
  assign res_o.tck_ok        = res_held.tck_ok;

  a_stall_only_on_pending: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !atr_i.ready |-> (res_o.valid && !res_o.ready))
    else $error("input stalled without a pending result");

  a_result_follows_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (atr_i.valid && atr_i.ready && atr_i.last_byte) |=> res_o.valid)
    else $error("no result after last item");

  a_no_result_without_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!res_o.valid || res_o.ready) |=>
      (!res_o.valid || $past(atr_i.valid && atr_i.ready && atr_i.last_byte)))
    else $error("result without a last item");

  a_ok_needs_checked: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_o.valid && res_o.tck_ok) |-> res_o.tck_checked)
    else $error("tck_ok set without tck_checked");

endmodule
